>>> src/assert_macros.svh
// Assertion macros for the SHA-512 hasher RTL.
// Bodies compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> src/sha512h_pkg.sv
// Package for the SHA-512 stream hasher: payload types, command and status
// structs, round constants, initial hash values and a 64-bit rotate function.
package sha512h_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 80;
  localparam int unsigned PadLimit   = 112;
  localparam int unsigned BlockBytes = 128;
  localparam logic [7:0]  PadByte    = 8'h80;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    SelZero = 3'd0,
    SelByte = 3'd1,
    SelPad  = 3'd2
  } byte_sel_e;

  typedef struct packed {
    logic      put_byte;
    byte_sel_e byte_sel;
    logic      count_byte;
    logic      put_length;
    logic      start_comp;
    logic      round;
    logic      finish_comp;
    logic      restart;
  } dp_cmd_t;

  typedef struct packed {
    logic [6:0] fill;
    logic [6:0] round_idx;
  } dp_status_t;

  localparam logic [63:0] RoundK [Rounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
    64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
    64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
    64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
    64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
    64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
    64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
    64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
    64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
    64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
    64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
    64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
    64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
    64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
    64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
    64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
    64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
    64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
    64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
    64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
    64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [63:0] InitHash [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  function automatic logic [63:0] ror64(logic [63:0] x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage

>>> src/sha512h_ctrl.sv
// Controller for the SHA-512 stream hasher: sequences byte loads, padding,
// compression rounds and digest output. Depends on sha512h_pkg.
module sha512h_ctrl
  import sha512h_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] out_idx_o,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StComp  = 7'b0000010,
    StFin   = 7'b0000100,
    StPad   = 7'b0001000,
    StLen   = 7'b0010000,
    StOut   = 7'b0100000,
    StDone  = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic       last_q, last_d;   // compression belongs to the final padding
  logic       final_q, final_d; // length block already loaded
  logic       pad_q, pad_d;     // pad byte already written
  logic [2:0] idx_q, idx_d;

  logic acc;
  assign acc = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_idx_o   = idx_q;

  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    final_d = final_q;
    pad_d   = pad_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.byte_sel = SelZero;
    case (state_q)
      StIdle: begin
        if (acc) begin
          if (in_item_i.byte_present) begin
            cmd_o.put_byte   = 1'b1;
            cmd_o.byte_sel   = SelByte;
            cmd_o.count_byte = 1'b1;
          end
          last_d  = in_item_i.is_last;
          final_d = 1'b0;
          pad_d   = 1'b0;
          if (in_item_i.byte_present && status_i.fill == 7'd127) begin
            cmd_o.start_comp = 1'b1;
            state_d = StComp;
          end else if (in_item_i.is_last) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        // pad byte first, then zeros up to the length field or block end
        cmd_o.put_byte = 1'b1;
        cmd_o.byte_sel = SelPad;
        pad_d = 1'b1;
        if (status_i.fill == 7'd127) begin
          cmd_o.start_comp = 1'b1;
          state_d = StComp;
        end else begin
          state_d = StLen;
        end
      end
      StLen: begin
        if (status_i.fill > 7'(PadLimit)) begin
          cmd_o.put_byte = 1'b1;
          cmd_o.byte_sel = SelZero;
          if (status_i.fill == 7'd127) begin
            cmd_o.start_comp = 1'b1;
            state_d = StComp;
          end
        end else if (status_i.fill < 7'(PadLimit)) begin
          cmd_o.put_byte = 1'b1;
          cmd_o.byte_sel = SelZero;
        end else begin
          cmd_o.put_length = 1'b1;
          cmd_o.start_comp = 1'b1;
          final_d = 1'b1;
          state_d = StComp;
        end
      end
      StComp: begin
        cmd_o.round = 1'b1;
        if (status_i.round_idx == 7'(Rounds - 1)) state_d = StFin;
      end
      StFin: begin
        cmd_o.finish_comp = 1'b1;
        if (!last_q) state_d = StIdle;
        else if (final_q) begin
          idx_d = '0;
          state_d = StOut;
        end else if (pad_q) state_d = StLen;
        else state_d = StPad;
      end
      StOut: begin
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) state_d = StDone;
        end
      end
      StDone: begin
        cmd_o.restart = 1'b1;
        last_d  = 1'b0;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      last_q  <= 1'b0;
      final_q <= 1'b0;
      pad_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
      final_q <= final_d;
      pad_q   <= pad_d;
      idx_q   <= idx_d;
    end
  end

endmodule

>>> src/sha512h_datapath.sv
// Datapath for the SHA-512 stream hasher: block buffer, message schedule,
// one round per cycle, chain value and bit count. Depends on sha512h_pkg.
module sha512h_datapath
  import sha512h_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  msg_byte_i,
  input  dp_cmd_t     cmd_i,
  input  logic [2:0]  out_idx_i,
  output logic [63:0] digest_o,
  output dp_status_t  status_o
);

  logic [63:0]  blk_q [BlockWords];
  logic [63:0]  w_q   [BlockWords];
  logic [63:0]  v_q   [8];
  logic [63:0]  h_q   [8];
  logic [127:0] cnt_q;
  logic [6:0]   fill_q;
  logic [6:0]   rnd_q;

  logic [7:0]  bval;
  logic [3:0]  wsel;
  logic [5:0]  sh;
  logic [63:0] s0, s1, wnew, t1, t2;
  logic [63:0] a, b, c, d, e, f, g, h;

  always_comb begin
    case (cmd_i.byte_sel)
      SelByte: bval = msg_byte_i;
      SelPad:  bval = PadByte;
      default: bval = 8'h00;
    endcase
  end

  assign wsel = fill_q[6:3];
  assign sh   = {~fill_q[2:0], 3'b000};

  assign a = v_q[0]; assign b = v_q[1]; assign c = v_q[2]; assign d = v_q[3];
  assign e = v_q[4]; assign f = v_q[5]; assign g = v_q[6]; assign h = v_q[7];

  assign s0   = ror64(w_q[1], 1) ^ ror64(w_q[1], 8) ^ (w_q[1] >> 7);
  assign s1   = ror64(w_q[14], 19) ^ ror64(w_q[14], 61) ^ (w_q[14] >> 6);
  assign wnew = w_q[0] + s0 + w_q[9] + s1;
  assign t1 = h + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41))
            + ((e & f) ^ (~e & g)) + RoundK[rnd_q] + w_q[0];
  assign t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39))
            + ((a & b) ^ (a & c) ^ (b & c));

  assign digest_o = h_q[out_idx_i];
  assign status_o.fill      = fill_q;
  assign status_o.round_idx = rnd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.put_byte) begin
      blk_q[wsel] <= (blk_q[wsel] & ~(64'hff << sh)) | (64'(bval) << sh);
    end
    if (cmd_i.put_length) begin
      blk_q[14] <= cnt_q[127:64];
      blk_q[15] <= cnt_q[63:0];
    end
    if (cmd_i.start_comp) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      for (int i = 0; i < 14; i++) w_q[i] <= blk_q[i];
      if (cmd_i.put_length) begin
        w_q[14] <= cnt_q[127:64];
        w_q[15] <= cnt_q[63:0];
      end else if (cmd_i.put_byte) begin
        w_q[14] <= blk_q[14];
        w_q[15] <= (blk_q[15] & ~64'hff) | 64'(bval);
      end else begin
        w_q[14] <= blk_q[14];
        w_q[15] <= blk_q[15];
      end
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
      v_q[7] <= g; v_q[6] <= f; v_q[5] <= e; v_q[4] <= d + t1;
      v_q[3] <= c; v_q[2] <= b; v_q[1] <= a; v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
      cnt_q  <= '0;
      fill_q <= '0;
      rnd_q  <= '0;
    end else begin
      if (cmd_i.put_byte) fill_q <= fill_q + 7'd1;
      if (cmd_i.count_byte) cnt_q <= cnt_q + 128'd8;
      if (cmd_i.round) rnd_q <= (rnd_q == 7'(Rounds - 1)) ? 7'd0 : rnd_q + 7'd1;
      if (cmd_i.finish_comp) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (cmd_i.put_length) fill_q <= '0;
      if (cmd_i.restart) begin
        for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
        cnt_q  <= '0;
        fill_q <= '0;
      end
    end
  end

endmodule

>>> src/sha512_stream_hasher_unit.sv
// SHA-512 stream hasher: at most one message byte per input item, eight digest words
// out. Top level joining sha512h_ctrl and sha512h_datapath; uses sha512h_pkg.
//
// Usage:
//  Input channel in_valid_i/in_ready_o carries in_item_i (msg_byte,
//  byte_present, is_last). Output channel out_valid_o/out_ready_i carries
//  out_item_o (digest_word, word_index, last_word).
//  A byte that does not complete a 128-byte block is written to the buffer.
//  A byte that completes a block loads it and runs 80 rounds, one per cycle
//  in the shared round unit, then the chain-value update.
//  A last item pads byte by byte and runs one or two compressions, then
//  presents the eight digest words, one per cycle while out_ready_i is
//  high; a restart from the initial hash follows the last word.
//  No new item is accepted while the round loop runs.
//  When the receiver stalls the current digest word holds and no new
//  item is accepted until all eight words are taken.
//  Reset loads the initial hash values and clears the bit count and fill.
module sha512_stream_hasher_unit
  import sha512h_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

`include "assert_macros.svh"

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [2:0] out_idx;
  logic [63:0] digest;

  sha512h_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_idx_o(out_idx),
    .cmd_o(cmd), .status_i(status)
  );

  sha512h_datapath u_dp (
    .clk_i, .rst_ni, .msg_byte_i(in_item_i.msg_byte), .cmd_i(cmd),
    .out_idx_i(out_idx), .digest_o(digest), .status_o(status)
  );

  assign out_item_o.digest_word = digest;
  assign out_item_o.word_index  = out_idx;
  assign out_item_o.last_word   = (out_idx == 3'd7);

  `ASSERT_IMPLIES(a_no_in_while_out, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `ASSERT_IMPLIES(a_round_busy, clk_i, rst_ni, cmd.round, !out_valid_o && !in_ready_o)
  `ASSERT_NEXT(a_idx_step, clk_i, rst_ni, out_valid_o && out_ready_i && out_idx != 3'd7,
    out_valid_o)

endmodule

>>> tb/sv/tb_sha512_stream_hasher_unit.sv
// Testbench for sha512_stream_hasher_unit: byte-stream messages in, digest words out.
// Uses sha512h_pkg types; holds its own SHA-512 predictor and checks every digest word.
`timescale 1ns / 100ps

class digest_board;
  logic [63:0]  round_consts [80];
  logic [63:0]  start_hash [8];
  logic [63:0]  chain [8];
  logic [63:0]  blk [16];
  logic [127:0] msg_bits;
  int unsigned  fill;
  sha512h_pkg::out_item_t pending_words [$];
  int unsigned  fail_count;

  function new();
    round_consts = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
      64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
      64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
      64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
      64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
      64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
      64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
      64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
      64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
      64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
      64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
      64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
      64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
      64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
      64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
      64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
      64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
      64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
      64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
      64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
      64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
    start_hash = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
      64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
    chain = start_hash;
    foreach (blk[i]) blk[i] = '0;
    msg_bits = '0;
    fill = 0;
    fail_count = 0;
  endfunction

  function logic [63:0] rotr(logic [63:0] x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function void compress();
    logic [63:0] w [80];
    logic [63:0] v [8];
    logic [63:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 80; i++)
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 1) ^ rotr(w[i-15], 8) ^ (w[i-15] >> 7))
           + (rotr(w[i-2], 19) ^ rotr(w[i-2], 61) ^ (w[i-2] >> 6));
    v = chain;
    for (int i = 0; i < 80; i++) begin
      t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_consts[i] + w[i];
      t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endfunction

  function void put(logic [7:0] b);
    blk[fill / 8][(7 - fill % 8) * 8 +: 8] = b;
    fill++;
  endfunction

  function void note_item(sha512h_pkg::in_item_t it);
    sha512h_pkg::out_item_t o;
    if (it.byte_present) begin
      put(it.msg_byte);
      msg_bits += 128'd8;
      if (fill == 128) begin
        compress();
        fill = 0;
      end
    end
    if (!it.is_last) return;
    put(8'h80);
    if (fill > 112) begin
      while (fill < 128) put(8'h00);
      compress();
      fill = 0;
    end
    while (fill < 112) put(8'h00);
    blk[14] = msg_bits[127:64];
    blk[15] = msg_bits[63:0];
    compress();
    for (int i = 0; i < 8; i++) begin
      o.digest_word = chain[i];
      o.word_index = 3'(i);
      o.last_word = (i == 7);
      pending_words.push_back(o);
    end
    chain = start_hash;
    msg_bits = '0;
    fill = 0;
  endfunction

  function void check_word(sha512h_pkg::out_item_t got);
    sha512h_pkg::out_item_t exp;
    if (pending_words.size() == 0) begin
      $error("unexpected digest word %h", got.digest_word);
      fail_count++;
      return;
    end
    exp = pending_words.pop_front();
    if (got.digest_word !== exp.digest_word) begin
      $error("digest_word exp %h got %h", exp.digest_word, got.digest_word);
      fail_count++;
    end
    if (got.word_index !== exp.word_index) begin
      $error("word_index exp %0d got %0d", exp.word_index, got.word_index);
      fail_count++;
    end
    if (got.last_word !== exp.last_word) begin
      $error("last_word exp %0d got %0d", exp.last_word, got.last_word);
      fail_count++;
    end
  endfunction
endclass

module tb_sha512_stream_hasher_unit;
  import sha512h_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  digest_board board = new();
  int unsigned burst_left = 0;
  int unsigned rx_phase = 0;
  int unsigned sent = 0;

  sha512_stream_hasher_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver: long ready stretches, then stall windows of varying style
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 1;
    if (rx_phase % 400 < 150) out_ready_i <= 1'b1;
    else if (rx_phase % 400 < 300) out_ready_i <= ($urandom_range(0, 3) != 0);
    else out_ready_i <= ($urandom_range(0, 5) == 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_word(out_item_o);
  end

  task automatic send_item(logic [7:0] b, logic present, logic last);
    in_item_t it;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    it.msg_byte = b;
    it.byte_present = present;
    it.is_last = last;
    in_item_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(it);
    sent++;
  endtask

  task automatic send_message(int unsigned len, bit empty_tail, int unsigned noise);
    for (int i = 0; i < len; i++) begin
      if (noise != 0 && $urandom_range(0, noise) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (i == len - 1) && !empty_tail);
    end
    if (empty_tail || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty message, extremes, single-byte and three-byte messages
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'ha5, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // padding boundaries: 111, 112, 127, 128 byte tails
    send_message(111, 0, 0);
    send_message(112, 1, 0);
    send_message(127, 0, 0);
    send_message(128, 0, 0);
    while (sent < 500) begin
      case ($urandom_range(0, 5))
        0: send_message($urandom_range(0, 3), $urandom_range(0, 1), 3);
        1: send_message($urandom_range(105, 135), $urandom_range(0, 1), 20);
        default: send_message($urandom_range(1, 40), $urandom_range(0, 1), 8);
      endcase
    end
    in_valid_i <= 1'b0;
    while (board.pending_words.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (board.fail_count == 0) begin
      $display("tb_sha512_stream_hasher_unit: clean");
    end else begin
      $display("tb_sha512_stream_hasher_unit: errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_sha512_stream_hasher_unit: errors");
    $finish;
  end
endmodule
